// File: rtl/wli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wli_pkg
// shared types and codes for the waypoint linear interpolator
// ----------------------------------------------------------------------------
package wli_pkg;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TEND_RD,
      ST_TEND_WT,
      ST_SCAN_RD,
      ST_SCAN_WT,
      ST_SCAN_CMP,
      ST_DIV,
      ST_LERP_RD,
      ST_LERP_WT,
      ST_LERP_MUL,
      ST_LERP_ADD,
      ST_OUT
   } state_type;

   // divider handshake
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: rtl/wli_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wli_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wli_divider #(
   parameter int ALPHA_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  wli_pkg::div_ctrl_type      ctrl,
   input  logic [31:0]                numer,
   input  logic [31:0]                denom,
   output wli_pkg::div_stat_type      stat,
   output logic [ALPHA_BITS:0]        quot
);
   localparam int NB = 32 + ALPHA_BITS;
   localparam int CW = $clog2(NB + 1);

   logic [NB-1:0] num_ff, num_in;
   logic [32:0]   rem_ff, rem_in;
   logic [NB-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [31:0]   den_ff, den_in;
   logic [32:0]   trial;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; q_in = q_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0; den_in = den_ff;
      trial = {rem_ff[31:0], num_ff[NB-1]};
      if (ctrl.start) begin
         num_in = {numer, {ALPHA_BITS{1'b0}}};
         den_in = denom;
         rem_in = '0; q_in = '0; cnt_in = CW'(NB); busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NB-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in = {q_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; q_ff <= q_in; den_ff <= den_in;
   end

   // tq - t0 <= t1 - t0 so the quotient never exceeds one
   assign quot = q_ff[ALPHA_BITS:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> busy_ff) else $error("divider not busy after start");
endmodule

// File: rtl/waypoint_linear_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_linear_interpolator
// waypoint table with time search, fraction divide and shared lerp multiplier
// ----------------------------------------------------------------------------
// channel   direction  content
// req_      in         command/slot (tuser), time and waypoint data (tdata)
// rsp_      out        interpolated pos/vel (tdata), segment/complete (tuser)
// csr_      in         waypoint_count write
//
// a load is written to the table on acceptance and ready stays high; a query
// raises rsp_tvalid after reading the end time (ST_TEND_RD, ST_TEND_WT), a
// table scan (ST_SCAN_RD, ST_SCAN_WT, ST_SCAN_CMP per entry, one read port),
// the bit-serial divide, skipped when alpha is fixed at zero or one, and a lerp
// per field (ST_LERP_RD, ST_LERP_WT per row, then ST_LERP_MUL, ST_LERP_ADD)
// reset clears control and sets waypoint_count to 2; table contents stay
// undefined until loaded
// req_tready is low from query acceptance until the result has been taken
// ----------------------------------------------------------------------------
module waypoint_linear_interpolator #(
   parameter int MAX_WAYPOINTS = 64,
   parameter int ALPHA_BITS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // time_ticks, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   input  logic [223:0] req_tdata,
   // command, slot
   input  logic [6:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z
   output logic [191:0] rsp_tdata,
   // segment, complete
   output logic [6:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [6:0]   csr_wdata
);
   localparam int AW = $clog2(MAX_WAYPOINTS);
   localparam int NW = AW + 1;

   // table memory: arrival plus six fields per row
   logic [223:0] mem [MAX_WAYPOINTS];
   logic [223:0] rd_ff;
   logic [AW-1:0] raddr;

   wli_pkg::state_type state_ff, state_in;
   logic [6:0]    count_ff;
   logic [NW-1:0] n;            // clamped waypoint count
   logic [31:0]   tq_ff, tq_in, t_ff, t0_ff, t0_in;
   logic          cmp_ff, cmp_in;
   logic [AW-1:0] idx_ff, idx_in;   // scan / segment index
   logic [AW-1:0] seg_ff, seg_in;
   logic [ALPHA_BITS:0] alpha_ff, alpha_in;
   logic [2:0]    fld_ff, fld_in;   // field being interpolated
   logic          hi_ff, hi_in;     // reading p1 row
   logic signed [31:0] p0_ff, p0_in;
   logic signed [32:0] d_ff, d_in;
   logic signed [33+ALPHA_BITS:0] prod_ff;
   logic [31:0]   res_ff [6];
   logic          cmpl_ff, cmpl_in;
   logic [31:0]   t1;
   logic          load_go;
   wli_pkg::div_ctrl_type dctl;
   wli_pkg::div_stat_type dst;
   logic [ALPHA_BITS:0]   dq;
   logic [31:0]   fsel;

   always_comb begin
      if (count_ff < 7'd2) n = NW'(2);
      else if ({25'd0, count_ff} > 32'(MAX_WAYPOINTS)) n = NW'(MAX_WAYPOINTS);
      else n = NW'(count_ff);
   end

   assign req_tready = (state_ff == wli_pkg::ST_IDLE);
   assign load_go = req_tvalid && req_tready && (req_tuser[0] == wli_pkg::CMD_LOAD)
                    && ({26'd0, req_tuser[6:1]} < 32'(MAX_WAYPOINTS));
   assign t1 = rd_ff[31:0];

   // memory address
   always_comb begin
      raddr = idx_ff;
      case (state_ff)
         wli_pkg::ST_TEND_RD: raddr = AW'(n - NW'(1));
         wli_pkg::ST_LERP_RD: raddr = hi_ff ? AW'(seg_ff + 1'b1) : seg_ff;
         default:             raddr = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_go) mem[AW'(req_tuser[6:1])] <= req_tdata;
      rd_ff <= mem[raddr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wli_pkg::ST_IDLE:
            if (req_tvalid && req_tuser[0] == wli_pkg::CMD_QUERY)
               state_in = wli_pkg::ST_TEND_RD;
         wli_pkg::ST_TEND_RD:  state_in = wli_pkg::ST_TEND_WT;
         wli_pkg::ST_TEND_WT:  state_in = wli_pkg::ST_SCAN_RD;
         wli_pkg::ST_SCAN_RD:  state_in = wli_pkg::ST_SCAN_WT;
         wli_pkg::ST_SCAN_WT:  state_in = wli_pkg::ST_SCAN_CMP;
         wli_pkg::ST_SCAN_CMP:
            if (idx_ff == AW'(0)) state_in = wli_pkg::ST_SCAN_RD;
            else if (tq_ff <= t1) state_in = wli_pkg::ST_DIV;
            else if ({1'b0, idx_ff} == NW'(n - NW'(1)))
               state_in = wli_pkg::ST_LERP_RD;
            else state_in = wli_pkg::ST_SCAN_RD;
         wli_pkg::ST_DIV:
            if (dst.done || !cmp_ff) state_in = wli_pkg::ST_LERP_RD;
         wli_pkg::ST_LERP_RD:  state_in = wli_pkg::ST_LERP_WT;
         wli_pkg::ST_LERP_WT:  state_in = hi_ff ? wli_pkg::ST_LERP_MUL
                                                : wli_pkg::ST_LERP_RD;
         wli_pkg::ST_LERP_MUL: state_in = wli_pkg::ST_LERP_ADD;
         wli_pkg::ST_LERP_ADD: state_in = (fld_ff == 3'd5) ? wli_pkg::ST_OUT
                                                           : wli_pkg::ST_LERP_RD;
         wli_pkg::ST_OUT:      if (rsp_tready) state_in = wli_pkg::ST_IDLE;
         default:              state_in = wli_pkg::ST_IDLE;
      endcase
   end

   // field select from row
   always_comb begin
      case (fld_ff)
         3'd0:    fsel = rd_ff[63:32];
         3'd1:    fsel = rd_ff[95:64];
         3'd2:    fsel = rd_ff[127:96];
         3'd3:    fsel = rd_ff[159:128];
         3'd4:    fsel = rd_ff[191:160];
         default: fsel = rd_ff[223:192];
      endcase
   end

   // datapath updates
   always_comb begin
      tq_in = tq_ff; t0_in = t0_ff; cmp_in = cmp_ff; idx_in = idx_ff;
      seg_in = seg_ff; alpha_in = alpha_ff; fld_in = fld_ff; hi_in = hi_ff;
      p0_in = p0_ff; d_in = d_ff; cmpl_in = cmpl_ff;
      dctl.start = 1'b0;
      case (state_ff)
         wli_pkg::ST_IDLE: begin
            idx_in = '0; fld_in = '0; hi_in = 1'b0;
            seg_in = AW'(n - NW'(2));
            alpha_in = (ALPHA_BITS+1)'(1) << ALPHA_BITS;
         end
         wli_pkg::ST_TEND_WT: begin
            tq_in = (t_ff > t1) ? t1 : t_ff;
            cmpl_in = (t_ff >= t1);
         end
         wli_pkg::ST_SCAN_CMP: begin
            if (idx_ff == AW'(0)) begin
               t0_in = t1; idx_in = AW'(1);
            end else if (tq_ff <= t1) begin
               seg_in = idx_ff - 1'b1;
               cmp_in = (t1 > t0_ff) && (tq_ff >= t0_ff);
               if (t1 > t0_ff && tq_ff < t0_ff) alpha_in = '0;
               dctl.start = (t1 > t0_ff) && (tq_ff >= t0_ff);
            end else begin
               t0_in = t1; idx_in = idx_ff + 1'b1;
            end
         end
         wli_pkg::ST_DIV:
            if (dst.done) alpha_in = dq;
         wli_pkg::ST_LERP_WT:
            if (!hi_ff) begin
               p0_in = fsel; hi_in = 1'b1;
            end else begin
               d_in = 33'(signed'(fsel)) - 33'(p0_ff);
               hi_in = 1'b0;
            end
         wli_pkg::ST_LERP_ADD: fld_in = fld_ff + 1'b1;
         default: ;
      endcase
   end

   // divisor is the segment span read in the same cycle as the start
   wli_divider #(.ALPHA_BITS(ALPHA_BITS)) u_div (
      .clock(clock), .reset(reset), .ctrl(dctl),
      .numer(tq_ff - t0_ff), .denom(t1 - t0_ff), .stat(dst), .quot(dq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wli_pkg::ST_IDLE;
         count_ff <= 7'd2;
      end else begin
         state_ff <= state_in;
         if (csr_we) count_ff <= csr_wdata;
      end
      if (req_tvalid && req_tready) t_ff <= req_tdata[31:0];
      tq_ff <= tq_in; t0_ff <= t0_in; cmp_ff <= cmp_in; idx_ff <= idx_in;
      seg_ff <= seg_in; alpha_ff <= alpha_in; fld_ff <= fld_in; hi_ff <= hi_in;
      p0_ff <= p0_in; d_ff <= d_in; cmpl_ff <= cmpl_in;
      // arithmetic shift floors toward minus infinity
      if (state_ff == wli_pkg::ST_LERP_MUL)
         prod_ff <= d_ff * $signed({1'b0, alpha_ff});
      if (state_ff == wli_pkg::ST_LERP_ADD)
         res_ff[fld_ff] <= 32'(p0_ff + 32'(prod_ff >>> ALPHA_BITS));
   end

   assign rsp_tvalid = (state_ff == wli_pkg::ST_OUT);
   assign rsp_tdata = {res_ff[5], res_ff[4], res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
   assign rsp_tuser = {cmpl_ff, 6'(seg_ff)};

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != wli_pkg::ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      dst.done |-> state_ff == wli_pkg::ST_DIV) else $error("stray divider result");
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wli_pkg::ST_LERP_MUL) |->
      alpha_ff <= ((ALPHA_BITS+1)'(1) << ALPHA_BITS)) else $error("alpha above one");
   a_seg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, seg_ff} <= NW'(n - NW'(2)))) else $error("segment range");
endmodule
